// ----- rtl/abbd_pkg.sv -----
// Shared constants, types and coefficient table for the burst byte demodulator.
package abbd_pkg;

    localparam int FIR_TAPS     = 41;
    localparam int PEAK_WINDOW  = 41;
    localparam int SIGNAL_DELAY = 20;
    localparam int SAMPLE_BITS  = 16;
    localparam int AMP_DEPTH    = 64;
    localparam int RISE_LAG     = 30;
    localparam int AMP_AW       = $clog2(AMP_DEPTH);
    localparam int SWEEP_N      = (PEAK_WINDOW > RISE_LAG) ? PEAK_WINDOW : RISE_LAG + 1;
    // MAC steps also cover the sweep over the older history entries
    localparam int MAC_LAST     = (FIR_TAPS > SWEEP_N - 1) ? FIR_TAPS : SWEEP_N - 1;
    localparam int STEP_W       = 7;
    localparam int COEF_W       = 18;
    localparam int PROD_W       = COEF_W + SAMPLE_BITS;
    localparam int ACC_W        = 48;
    localparam int VAL_W        = 24;
    localparam logic [23:0] DECAY_K = 24'd16775539;
    localparam logic [6:0]  WARMUP  = 7'd64;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_CONT = 2'd1,
        ST_ERR  = 2'd2,
        ST_END  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_BIT_PERIOD   = 3'd0,
        CFG_BURST_LENGTH = 3'd1,
        CFG_TALLY_THRESH = 3'd2,
        CFG_INACT_LIMIT  = 3'd3,
        CFG_START_RATIO  = 3'd4,
        CFG_SYNC_VALUE   = 3'd5,
        CFG_SYNC_COUNT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DIVW, S_POST1, S_POST2, S_POST3, S_POST4,
        S_DEC, S_FRAME
    } t_state;

    typedef struct packed {
        logic load;
        logic mac;
        logic post1;
        logic post2;
        logic post3;
        logic post4;
        logic dec;
        logic frame;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
        logic div_done;
        logic out_free;
    } t_stat;

    // Symmetric high-pass taps, Q1.17
    function automatic logic signed [COEF_W-1:0] fir_coef(input logic [5:0] idx);
        logic [5:0] m;
        logic signed [COEF_W-1:0] c;
        m = (idx > 6'd20) ? 6'(6'd40 - idx) : idx;
        case (m)
            6'd0:    c = 18'sd498;
            6'd1:    c = -18'sd1331;
            6'd2:    c = -18'sd1048;
            6'd3:    c = -18'sd988;
            6'd4:    c = -18'sd804;
            6'd5:    c = -18'sd372;
            6'd6:    c = 18'sd312;
            6'd7:    c = 18'sd1172;
            6'd8:    c = 18'sd2048;
            6'd9:    c = 18'sd2734;
            6'd10:   c = 18'sd2999;
            6'd11:   c = 18'sd2630;
            6'd12:   c = 18'sd1481;
            6'd13:   c = -18'sd491;
            6'd14:   c = -18'sd3198;
            6'd15:   c = -18'sd6430;
            6'd16:   c = -18'sd9865;
            6'd17:   c = -18'sd13115;
            6'd18:   c = -18'sd15788;
            6'd19:   c = -18'sd17546;
            6'd20:   c = 18'sd112913;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/abbd_ctrl.sv -----
// Sequencer for the per-sample processing steps.
module abbd_ctrl import abbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_eod,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_eod ? S_FRAME : S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (i_stat.mac_done) n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) n_state = S_POST1;
            end
            S_POST1: begin
                o_cmd.post1 = 1'b1;
                n_state     = S_POST2;
            end
            S_POST2: begin
                o_cmd.post2 = 1'b1;
                n_state     = S_POST3;
            end
            S_POST3: begin
                o_cmd.post3 = 1'b1;
                n_state     = S_POST4;
            end
            S_POST4: begin
                o_cmd.post4 = 1'b1;
                n_state     = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_FRAME;
            end
            S_FRAME: begin
                if (i_stat.out_free) begin
                    o_cmd.frame = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/abbd_datapath.sv -----
// Filter chain, peak tracker, decision logic, byte framer and output register.
module abbd_datapath import abbd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_restart,
    input  logic                   i_eod,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_addr,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [7:0]             o_byte,
    output logic [VAL_W-1:0]       o_level
);

    // configuration
    logic [7:0]  r_bit_period, r_burst_len, r_tally_thr, r_sync_value;
    logic [15:0] r_inact_lim;
    logic [5:0]  r_start_ratio;
    logic [3:0]  r_sync_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= 8'd88;
            r_burst_len   <= 8'd64;
            r_tally_thr   <= 8'd30;
            r_inact_lim   <= 16'd10000;
            r_start_ratio <= 6'd15;
            r_sync_value  <= 8'hAA;
            r_sync_count  <= 4'd5;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BIT_PERIOD:   r_bit_period  <= i_cfg_data[7:0];
                CFG_BURST_LENGTH: r_burst_len   <= i_cfg_data[7:0];
                CFG_TALLY_THRESH: r_tally_thr   <= i_cfg_data[7:0];
                CFG_INACT_LIMIT:  r_inact_lim   <= i_cfg_data;
                CFG_START_RATIO:  r_start_ratio <= i_cfg_data[5:0];
                CFG_SYNC_VALUE:   r_sync_value  <= i_cfg_data[7:0];
                CFG_SYNC_COUNT:   r_sync_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [7:0] w_bp;
    assign w_bp = (r_bit_period == 8'd0) ? 8'd1 : r_bit_period;

    logic [STEP_W-1:0] r_step;
    logic              r_eod;

    // FIR: delay line rotates under a single MAC, tap 0 is always the operand
    logic signed [SAMPLE_BITS-1:0] r_taps [FIR_TAPS];
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    // filters
    logic [VAL_W-1:0] r_rect [7];
    logic [VAL_W-1:0] r_med  [5];
    logic [VAL_W-1:0] r_sd   [SIGNAL_DELAY+1];
    logic [VAL_W-1:0] r_x;
    logic [47:0]      r_decay;
    logic [VAL_W-1:0] r_amp_last;

    // amplitude history memory
    logic [VAL_W-1:0]  r_hist [AMP_DEPTH];
    logic [AMP_AW-1:0] r_wp;
    logic [AMP_AW:0]   r_fill;
    logic [VAL_W-1:0]  r_rd_data;
    logic [STEP_W-1:0] r_rd_age;
    logic              r_rd_pend;
    logic [VAL_W-1:0]  r_peak, r_h30;

    logic [6:0] r_dh [5];
    logic [6:0] r_warm;

    // framer state
    logic        r_active, r_in_byte;
    logic [16:0] r_since_act;
    logic [11:0] r_sbs;
    logic [9:0]  r_fbits;
    logic [3:0]  r_bseen;
    logic [7:0]  r_tally [6];

    // slot divider
    logic [11:0] r_div_q;
    logic [8:0]  r_div_r;
    logic [3:0]  r_div_cnt;
    logic        r_div_busy;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [7:0]       r_out_byte;
    logic [VAL_W-1:0] r_out_level;

    assign o_stat.mac_done   = (r_step == STEP_W'(MAC_LAST));
    assign o_stat.div_done   = !r_div_busy;
    assign o_stat.out_free   = !r_out_valid || i_ready;

    // ---------- post-processing combinational values ----------
    logic signed [ACC_W-1:0] w_rnd;
    logic [VAL_W-1:0]        w_abs;
    logic [VAL_W-1:0]        w_max7;
    logic [VAL_W-1:0]        w_median;
    logic [VAL_W-1:0]        w_amp;
    logic [AMP_AW-1:0]       w_wp_next;

    always_comb begin
        w_rnd = (r_acc + (ACC_W'(1) <<< (SAMPLE_BITS - 1))) >>> SAMPLE_BITS;
        if (w_rnd > ACC_W'(8388607)) begin
            w_abs = 24'd8388607;
        end else if (w_rnd < -ACC_W'(8388608)) begin
            w_abs = 24'd8388608;
        end else if (w_rnd < 0) begin
            w_abs = 24'((-w_rnd));
        end else begin
            w_abs = 24'(w_rnd);
        end
    end

    always_comb begin
        w_max7 = '0;
        for (int i = 0; i < 7; i++) begin
            if (r_rect[i] > w_max7) w_max7 = r_rect[i];
        end
    end

    // median by rank: ties broken by position, rank two wins
    always_comb begin
        logic [2:0] cnt;
        w_median = '0;
        for (int i = 0; i < 5; i++) begin
            cnt = '0;
            for (int j = 0; j < 5; j++) begin
                if (j != i && ((r_med[j] < r_med[i]) || (r_med[j] == r_med[i] && j < i)))
                    cnt = cnt + 3'd1;
            end
            if (cnt == 3'd2) w_median = r_med[i];
        end
    end

    assign w_amp     = (r_x > r_decay[47:24]) ? r_x : r_decay[47:24];
    assign w_wp_next = r_wp + AMP_AW'(1);

    // ---------- decision ----------
    logic [6:0]  w_dec;
    logic [28:0] w_lhs;
    logic [29:0] w_start_rhs;

    always_comb begin
        logic [2:0] votes;
        votes = '0;
        w_dec = '0;
        w_lhs = 29'(r_sd[SIGNAL_DELAY]) * 29'd20;
        for (int i = 0; i < 5; i++) begin
            if (w_lhs >= 29'(r_peak) * 29'(5 + i)) begin
                w_dec[i] = 1'b1;
                votes    = votes + 3'd1;
            end
        end
        w_dec[5]    = (votes >= 3'd3);
        w_start_rhs = 30'(r_start_ratio) * 30'(r_h30);
        w_dec[6]    = (30'(r_amp_last) >= w_start_rhs) && (r_warm == 7'd0);
    end

    logic [6:0] w_maj;
    always_comb begin
        logic [2:0] c;
        for (int b = 0; b < 7; b++) begin
            c = '0;
            for (int j = 0; j < 5; j++) c = c + 3'(r_dh[j][b]);
            w_maj[b] = (c >= 3'd3);
        end
    end

    // ---------- framer ----------
    logic        f_act, f_inb;
    logic [16:0] f_sa;
    logic [11:0] f_sbs, f_j;
    logic [7:0]  f_k;
    logic [9:0]  f_fb;
    logic [3:0]  f_bs;
    logic [7:0]  f_tal [6];
    logic [1:0]  f_st;
    logic [7:0]  f_byte;

    always_comb begin
        logic [3:0] score;
        logic [7:0] b;
        f_act   = r_active;
        f_inb   = r_in_byte;
        f_sa    = r_since_act;
        f_sbs   = r_sbs;
        f_fb    = r_fbits;
        f_bs    = r_bseen;
        f_tal   = r_tally;
        f_st    = ST_CONT;
        f_byte  = '0;
        f_j     = r_div_q;
        f_k     = r_div_r[7:0];
        score   = '0;
        b       = r_fbits[8:1];
        if (w_maj[6] && !f_act) begin
            f_act = 1'b1;
            f_sa  = '0;
            f_inb = 1'b0;
            f_bs  = '0;
        end
        if (!f_act) begin
            f_st = ST_CONT;
        end else if (f_sa > 17'(r_inact_lim)) begin
            f_st = ST_ERR;
        end else begin
            if (!f_inb && w_maj[5]) begin
                f_inb   = 1'b1;
                f_sa    = '0;
                f_sbs   = '0;
                if (f_bs != 4'd15) f_bs = f_bs + 4'd1;
                f_fb    = '0;
                for (int i = 0; i < 6; i++) f_tal[i] = '0;
                f_j     = '0;
                f_k     = '0;
            end
            if (!f_inb) begin
                f_st = ST_CONT;
            end else if (f_j >= 12'd10) begin
                if (!f_fb[0] || f_fb >= 10'd512) begin
                    f_st = ST_ERR;
                end else begin
                    b     = f_fb[8:1];
                    f_inb = 1'b0;
                    if (f_bs > r_sync_count) begin
                        f_st   = ST_BYTE;
                        f_byte = b;
                    end else begin
                        f_st = (b == r_sync_value) ? ST_CONT : ST_ERR;
                    end
                end
            end else begin
                f_st = ST_CONT;
                if (f_k < r_burst_len) begin
                    for (int i = 0; i < 6; i++)
                        if (w_maj[i] && f_tal[i] != 8'd255) f_tal[i] = f_tal[i] + 8'd1;
                end else if (f_k == r_burst_len) begin
                    for (int i = 0; i < 6; i++) begin
                        if (f_tal[i] >= r_tally_thr) score = score + ((i < 5) ? 4'd1 : 4'd2);
                        f_tal[i] = '0;
                    end
                    if (score >= 4'd4) f_fb = f_fb | (10'd1 << f_j[3:0]);
                end
            end
        end
    end

    // ---------- sequential datapath ----------
    logic [8:0] w_trial;
    assign w_trial = {r_div_r[7:0], r_div_q[11]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_eod       <= 1'b0;
            r_acc       <= '0;
            r_prod      <= '0;
            for (int i = 0; i < FIR_TAPS; i++) r_taps[i] <= '0;
            for (int i = 0; i < 7; i++) r_rect[i] <= '0;
            for (int i = 0; i < 5; i++) r_med[i] <= '0;
            for (int i = 0; i <= SIGNAL_DELAY; i++) r_sd[i] <= '0;
            for (int i = 0; i < 5; i++) r_dh[i] <= '0;
            for (int i = 0; i < 6; i++) r_tally[i] <= '0;
            r_amp_last  <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
            r_peak      <= '0;
            r_h30       <= '0;
            r_warm      <= WARMUP;
            r_active    <= 1'b0;
            r_in_byte   <= 1'b0;
            r_since_act <= '0;
            r_sbs       <= '0;
            r_fbits     <= '0;
            r_bseen     <= '0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !i_cmd.frame) r_out_valid <= 1'b0;

            if (i_cmd.load) begin
                logic        a, ib;
                logic [16:0] sa;
                logic [11:0] sb;
                a  = r_active;
                ib = r_in_byte;
                sa = r_since_act;
                sb = r_sbs;
                if (i_restart) begin
                    a  = 1'b0;
                    ib = 1'b0;
                    sa = '0;
                    sb = '0;
                end
                if (a && sa != 17'h1FFFF) sa = sa + 17'd1;
                if (ib && sb != 12'hFFF) sb = sb + 12'd1;
                r_active    <= a;
                r_in_byte   <= ib;
                r_since_act <= sa;
                r_sbs       <= sb;
                r_eod       <= i_eod;
                r_step      <= '0;
                r_acc       <= '0;
                r_peak      <= '0;
                r_h30       <= '0;
                if (!i_eod) begin
                    for (int i = FIR_TAPS - 1; i > 0; i--) r_taps[i] <= r_taps[i-1];
                    r_taps[0] <= i_sample;
                end
            end

            if (i_cmd.mac) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step < STEP_W'(FIR_TAPS)) begin
                    r_prod <= PROD_W'(fir_coef(r_step[5:0]) * r_taps[0]);
                    for (int i = 0; i < FIR_TAPS - 1; i++) r_taps[i] <= r_taps[i+1];
                    r_taps[FIR_TAPS-1] <= r_taps[0];
                end
                if (r_step != '0 && r_step <= STEP_W'(FIR_TAPS))
                    r_acc <= r_acc + ACC_W'(r_prod);
                // older history entries: step s reads age s + 1
                r_rd_pend <= (r_step < STEP_W'(SWEEP_N - 1));
                r_rd_age  <= r_step + STEP_W'(1);
                if (r_step == '0) begin
                    r_div_q    <= r_sbs;
                    r_div_r    <= '0;
                    r_div_cnt  <= '0;
                    r_div_busy <= 1'b1;
                end
            end

            // restoring divide: slot index and offset within slot
            if (r_div_busy) begin
                if (w_trial >= {1'b0, w_bp}) begin
                    r_div_r <= w_trial - {1'b0, w_bp};
                    r_div_q <= {r_div_q[10:0], 1'b1};
                end else begin
                    r_div_r <= w_trial;
                    r_div_q <= {r_div_q[10:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 4'd1;
                if (r_div_cnt == 4'd11) r_div_busy <= 1'b0;
            end

            if (i_cmd.post1) begin
                for (int i = 6; i > 0; i--) r_rect[i] <= r_rect[i-1];
                r_rect[0] <= w_abs;
            end
            if (i_cmd.post2) begin
                for (int i = 4; i > 0; i--) r_med[i] <= r_med[i-1];
                r_med[0] <= w_max7;
            end
            if (i_cmd.post3) begin
                for (int i = SIGNAL_DELAY; i > 0; i--) r_sd[i] <= r_sd[i-1];
                r_sd[0] <= w_median;
                r_x     <= w_median;
                r_decay <= 48'(r_amp_last) * 48'(DECAY_K);
            end
            if (i_cmd.post4) begin
                r_amp_last <= w_amp;
                r_wp       <= w_wp_next;
                if (r_fill != (AMP_AW+1)'(AMP_DEPTH)) r_fill <= r_fill + 1'b1;
                // newest entry joins the peak window
                r_peak     <= (w_amp > r_peak) ? w_amp : r_peak;
            end

            if (r_rd_pend) begin
                logic [VAL_W-1:0] v;
                v = (r_rd_age <= STEP_W'(r_fill)) ? r_rd_data : '0;
                if (r_rd_age < STEP_W'(PEAK_WINDOW) && v > r_peak) r_peak <= v;
                if (r_rd_age == STEP_W'(RISE_LAG)) r_h30 <= v;
            end

            if (i_cmd.dec) begin
                for (int i = 4; i > 0; i--) r_dh[i] <= r_dh[i-1];
                r_dh[0] <= w_dec;
                if (r_warm != 7'd0) r_warm <= r_warm - 7'd1;
            end

            if (i_cmd.frame) begin
                r_out_valid <= 1'b1;
                r_out_level <= r_amp_last;
                if (r_eod) begin
                    r_out_status <= ST_END;
                    r_out_byte   <= '0;
                end else begin
                    r_out_status <= f_st;
                    r_out_byte   <= f_byte;
                    r_active     <= f_act;
                    r_in_byte    <= f_inb;
                    r_since_act  <= f_sa;
                    r_sbs        <= f_sbs;
                    r_fbits      <= f_fb;
                    r_bseen      <= f_bs;
                    r_tally      <= f_tal;
                end
            end
        end
    end

    // history memory, registered read
    logic [AMP_AW-1:0] w_rd_addr;
    assign w_rd_addr = r_wp - r_step[AMP_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.post4) r_hist[w_wp_next] <= w_amp;
        r_rd_data <= r_hist[w_rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_byte   = r_out_byte;
    assign o_level  = r_out_level;

endmodule

// ----- rtl/acoustic_burst_byte_demodulator.sv -----
// Top level of the acoustic burst byte demodulator.
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | [15:0] sample                  | [0] restart, [1] end_of_data
//  m_axis   | out       | [7:0] data_byte, [31:8] level  | [1:0] status
//  cfg      | in        | write enable, 3-bit index, 16-bit data
//
// A sample passes through the shared FIR multiply-accumulate (the history memory
// sweep runs underneath), one divider check, four filter steps and one decision;
// its result registers in the framing step; only then is a new sample accepted.
// An end_of_data transaction skips the filters and goes straight to framing.
// Reset is synchronous, active low; filter state but r_x, r_decay clears at once.
// The result waits in an output register; a stalled m_axis holds the framing step.
module acoustic_burst_byte_demodulator import abbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic [1:0]  s_axis_tuser,   // [0] restart, [1] end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [31:8] level
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [7:0]       w_byte;
    logic [VAL_W-1:0] w_level;

    abbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_eod   (s_axis_tuser[1]),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    abbd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_restart  (s_axis_tuser[0]),
        .i_eod      (s_axis_tuser[1]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (m_axis_tuser),
        .o_byte     (w_byte),
        .o_level    (w_level)
    );

    assign m_axis_tdata = {w_level, w_byte};

endmodule

// ----- rtl/abbd_checker.sv -----
// Port-level checks for the demodulator, bound to the top level.
module abbd_checker import abbd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_addr,
    input logic [15:0] i_cfg_data
);

    // one sample in flight: ready drops after each transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is in work");

    // byte field is zero unless a byte is reported
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_BYTE) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("data byte set on a non-byte result");

    // end-of-data with no result waiting gets end status after framing
    a_end_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[1] && !m_axis_tvalid)
        |=> ##1 (m_axis_tvalid && m_axis_tuser == ST_END))
        else $error("end of data not reported");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind acoustic_burst_byte_demodulator abbd_checker u_abbd_checker (.*);
